### sv/tkts_pkg.sv
`timescale 1ns / 1ps

package tkts_pkg;

	localparam int DATA_W       = 16;
	localparam int KEEP_W       = 7;
	localparam int MAX_KEEP_DEF = 64;

	localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

	// controller -> datapath
	typedef struct packed {
		logic capture;    // latch the accepted sample
		logic decide;     // pick insert / replace / nothing, set up first reads
		logic up_step;    // one sift-up level
		logic down_step;  // one sift-down level
		logic load_out;   // load threshold register, clear the heap
	} tkts_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic do_insert;
		logic do_replace;
		logic up_done;
		logic down_done;
		logic last;
	} tkts_status_t;

endpackage

### sv/tkts_sample_if.sv
`timescale 1ns / 1ps

interface tkts_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [tkts_pkg::DATA_W-1:0] sample_value;
	logic                              last_in_run;

	modport source(output valid, output sample_value, output last_in_run, input ready);
	modport sink(input valid, input sample_value, input last_in_run, output ready);
endinterface

### sv/tkts_threshold_if.sv
`timescale 1ns / 1ps

interface tkts_threshold_if;
	logic                              valid;
	logic                              ready;
	logic signed [tkts_pkg::DATA_W-1:0] threshold_value;

	modport source(output valid, output threshold_value, input ready);
	modport sink(input valid, input threshold_value, output ready);
endinterface

### sv/tkts_ctrl.sv
`timescale 1ns / 1ps

module tkts_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  tkts_pkg::tkts_status_t st,
	output tkts_pkg::tkts_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_UP     = 3'd2;
	localparam logic [2:0] S_DOWN   = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				priority if (st.do_insert) state_d = S_UP;
				else if (st.do_replace)    state_d = S_DOWN;
				else                       state_d = S_FIN;
			end
			S_UP: begin
				cmd.up_step = 1'b1;
				if (st.up_done) state_d = S_FIN;
			end
			S_DOWN: begin
				cmd.down_step = 1'b1;
				if (st.down_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (!st.last) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)   out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

### sv/tkts_datapath.sv
`timescale 1ns / 1ps

module tkts_datapath #(
	parameter int MAX_KEEP = tkts_pkg::MAX_KEEP_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              keep_count_we,
	input  logic [tkts_pkg::KEEP_W-1:0]       keep_count_wdata,
	input  logic signed [tkts_pkg::DATA_W-1:0] in_value,
	input  logic                              in_last,
	output logic signed [tkts_pkg::DATA_W-1:0] out_value,
	input  tkts_pkg::tkts_cmd_t               cmd,
	output tkts_pkg::tkts_status_t            st
);

	localparam int DW   = tkts_pkg::DATA_W;
	localparam int AW   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int CW   = $clog2(MAX_KEEP + 1);
	localparam int LW   = AW + 2;
	localparam int CMPW = (CW > tkts_pkg::KEEP_W) ? CW : tkts_pkg::KEEP_W;

	// heap storage, min at index 0
	logic signed [DW-1:0] mem [MAX_KEEP];

	logic [tkts_pkg::KEEP_W-1:0] keep_q;
	logic [CW-1:0]               count_q;
	logic [AW-1:0]               idx_q;
	logic signed [DW-1:0]        x_q;
	logic                        last_q;
	logic signed [DW-1:0]        min_q;
	logic signed [DW-1:0]        out_q;
	logic signed [DW-1:0]        rd_a_q, rd_b_q;

	logic [AW-1:0]        raddr_a, raddr_b;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic signed [DW-1:0] wdata;

	// sift-up terms
	logic [AW-1:0] parent;
	logic [AW-1:0] gparent;
	logic          up_move;
	logic [AW-1:0] ins_parent;

	// sift-down terms
	logic [LW-1:0] n_ext;
	logic [LW-1:0] lch, rch;
	logic          l_in, r_in, pick_r;
	logic signed [DW-1:0] cval;
	logic [AW-1:0] cidx;
	logic          down_move;
	logic [AW-1:0] base;
	logic [LW-1:0] nl, nr;

	logic do_insert, do_replace;

	assign n_ext = LW'(count_q);

	assign do_insert = (count_q < CW'(MAX_KEEP)) &&
		((CMPW'(count_q) < CMPW'(keep_q)) || (count_q == '0));
	assign do_replace = (count_q != '0) && (min_q < x_q);

	assign ins_parent = (count_q == '0) ? '0 : AW'((count_q - CW'(1)) >> 1);

	assign parent  = (idx_q == '0) ? '0 : AW'((idx_q - AW'(1)) >> 1);
	assign gparent = (parent == '0) ? '0 : AW'((parent - AW'(1)) >> 1);
	assign up_move = (idx_q != '0) && (x_q < rd_a_q);

	assign lch    = {1'b0, idx_q, 1'b1};
	assign rch    = lch + LW'(1);
	assign l_in   = lch < n_ext;
	assign r_in   = rch < n_ext;
	assign pick_r = r_in && (rd_b_q < rd_a_q);
	assign cval   = pick_r ? rd_b_q : rd_a_q;
	assign cidx   = pick_r ? rch[AW-1:0] : lch[AW-1:0];
	assign down_move = l_in && (cval < x_q);

	// children of the node that becomes current next cycle
	assign base = cmd.decide ? '0 : cidx;
	assign nl   = {1'b0, base, 1'b1};
	assign nr   = nl + LW'(1);

	always_comb begin
		raddr_a = '0;
		raddr_b = '0;
		if (cmd.decide && do_insert) begin
			raddr_a = ins_parent;
		end else if (cmd.up_step) begin
			raddr_a = gparent;
		end else begin
			raddr_a = (nl < n_ext) ? nl[AW-1:0] : '0;
			raddr_b = (nr < n_ext) ? nr[AW-1:0] : '0;
		end
	end

	always_comb begin
		we    = cmd.up_step || cmd.down_step;
		waddr = idx_q;
		wdata = x_q;
		if (cmd.up_step && up_move)     wdata = rd_a_q;
		if (cmd.down_step && down_move) wdata = cval;
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q    <= in_value;
			last_q <= in_last;
		end
		if (we && (waddr == '0)) min_q <= wdata;
		if (cmd.load_out) out_q <= min_q;
		priority if (cmd.decide && do_insert)   idx_q <= AW'(count_q);
		else if (cmd.decide)                    idx_q <= '0;
		else if (cmd.up_step && up_move)        idx_q <= parent;
		else if (cmd.down_step && down_move)    idx_q <= cidx;
		else                                    idx_q <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q  <= tkts_pkg::KEEP_RESET;
			count_q <= '0;
		end else begin
			if (keep_count_we) keep_q <= keep_count_wdata;
			if (cmd.load_out)
				count_q <= '0;
			else if (cmd.decide && do_insert)
				count_q <= count_q + CW'(1);
		end
	end

	assign out_value     = out_q;
	assign st.do_insert  = do_insert;
	assign st.do_replace = do_replace;
	assign st.up_done    = !up_move;
	assign st.down_done  = !down_move;
	assign st.last       = last_q;

endmodule

### sv/top_k_threshold_select_unit.sv
`timescale 1ns / 1ps
// Channel    Dir  Payload                        Transfer
// sample     in   sample_value, last_in_run      valid & ready
// threshold  out  threshold_value                valid & ready
// keep_count in   keep_count_wdata (7 bits)      keep_count_we
//
// One sample at a time: accept, decide, then one heap level per step
// (sift-up on insert, sift-down on replace-minimum), then finish.
// The heap walk runs over the single storage array (one write, two registered
// reads per cycle).
// arst_n clears control and keep_count (to 1); heap contents need no clear.
// A stalled threshold register only holds the block when the next run ends.

module top_k_threshold_select_unit #(
	parameter int MAX_KEEP = tkts_pkg::MAX_KEEP_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tkts_sample_if.sink                 sample,
	tkts_threshold_if.source            threshold,
	input  logic                        keep_count_we,
	input  logic [tkts_pkg::KEEP_W-1:0] keep_count_wdata
);

	tkts_pkg::tkts_cmd_t    cmd;
	tkts_pkg::tkts_status_t st;

	// Controller: sequences decide / sift / finish and owns the output valid.
	tkts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (threshold.valid),
		.out_ready (threshold.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: min-heap in a local array; the root is mirrored in a register
	// so the replace test and the threshold need no memory read.
	tkts_datapath #(
		.MAX_KEEP (MAX_KEEP)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.keep_count_we    (keep_count_we),
		.keep_count_wdata (keep_count_wdata),
		.in_value         (sample.sample_value),
		.in_last          (sample.last_in_run),
		.out_value        (threshold.threshold_value),
		.cmd              (cmd),
		.st               (st)
	);

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	import tkts_pkg::*;

	// Tracks the keep_count largest values of the current run, as the block does.
	// Queues the threshold each run should produce and checks the outgoing ones.
	class threshold_tracker;
		logic [KEEP_W-1:0]        keep_reg;
		logic signed [DATA_W-1:0] held [MAX_KEEP_DEF];
		int unsigned              held_n;
		logic signed [DATA_W-1:0] thresholds_due [$];
		int unsigned              errors;

		function new();
			keep_reg = KEEP_RESET;
			held_n   = 0;
			errors   = 0;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_keep(logic [KEEP_W-1:0] value);
			keep_reg = value;
		endfunction

		function int unsigned smallest_slot();
			int unsigned best;
			best = 0;
			for (int unsigned i = 1; i < held_n && i < MAX_KEEP_DEF; i++)
				if (held[i] < held[best])
					best = i;
			return best;
		endfunction

		function void note_sample(logic signed [DATA_W-1:0] value, logic last);
			int unsigned k;
			int unsigned m;
			// zero acts as one, anything past the store size acts as the store size
			k = (keep_reg == 0) ? 1 : int'(keep_reg);
			if (k > MAX_KEEP_DEF)
				k = MAX_KEEP_DEF;
			if (held_n < k && held_n < MAX_KEEP_DEF) begin
				held[held_n] = value;
				held_n++;
			end else if (held_n > 0) begin
				// equal to the smallest held value: no replacement
				m = smallest_slot();
				if (held[m] < value)
					held[m] = value;
			end
			if (last) begin
				thresholds_due.push_back(held[smallest_slot()]);
				held_n = 0;
			end
		endfunction

		task check_threshold(logic signed [DATA_W-1:0] got);
			logic signed [DATA_W-1:0] want;
			if (thresholds_due.size() == 0) begin
				report_mismatch($sformatf("threshold %0d with none due", got));
				return;
			end
			want = thresholds_due.pop_front();
			if (got !== want)
				report_mismatch($sformatf("threshold_value got %0d expected %0d", got, want));
		endtask

		function int unsigned pending();
			return thresholds_due.size();
		endfunction
	endclass

	// Idle time after the last threshold, sized above the worst per-sample heap walk.
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 600;
	localparam int PHASE_ITEMS   = 185;

	logic clk = 1'b0;
	logic arst_n;
	logic keep_count_we;
	logic [KEEP_W-1:0] keep_count_wdata;

	tkts_sample_if    sample ();
	tkts_threshold_if threshold ();

	top_k_threshold_select_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample           (sample.sink),
		.threshold        (threshold.source),
		.keep_count_we    (keep_count_we),
		.keep_count_wdata (keep_count_wdata)
	);

	threshold_tracker sb = new();

	int unsigned src_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned sent_count   = 0;
	bit          rx_hold_req  = 1'b0;
	int unsigned rx_hold_left = 0;

	always #1 clk = ~clk;

	// Monitor: sample both channels at the rising edge. The outgoing transfer
	// always belongs to an earlier run, so check it before noting the input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (threshold.valid && threshold.ready)
				sb.check_threshold(threshold.threshold_value);
			if (sample.valid && sample.ready)
				sb.note_sample(sample.sample_value, sample.last_in_run);
		end
	end

	// Receiver: random stalls, plus a long hold-off on request. The hold-off is
	// counted here so the sender keeps offering while the block backs up.
	initial begin
		threshold.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req  = 1'b0;
				rx_hold_left = HOLD_CYCLES;
			end
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				threshold.ready <= 1'b0;
			end else begin
				threshold.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic push_sample(input logic signed [DATA_W-1:0] value, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			sample.valid <= 1'b0;
			@(negedge clk);
		end
		sample.valid        <= 1'b1;
		sample.sample_value <= value;
		sample.last_in_run  <= last;
		do
			@(posedge clk);
		while (!sample.ready);
		sent_count++;
		@(negedge clk);
	endtask

	// Block is idle once no threshold is due and the last sample has walked the heap.
	task automatic settle();
		sample.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic load_keep(input logic [KEEP_W-1:0] value);
		keep_count_we    <= 1'b1;
		keep_count_wdata <= value;
		@(negedge clk);
		keep_count_we    <= 1'b0;
		sb.set_keep(value);
	endtask

	// One run of len samples; retune_at > 0 changes keep_count before that sample.
	task automatic send_run(input int unsigned len, input int unsigned retune_at);
		logic signed [DATA_W-1:0] pool [4];
		logic signed [DATA_W-1:0] v;
		for (int i = 0; i < 4; i++)
			pool[i] = DATA_W'($urandom);
		for (int unsigned i = 0; i < len; i++) begin
			if (retune_at != 0 && i == retune_at) begin
				settle();
				load_keep(KEEP_W'($urandom_range(0, 127)));
			end
			case ($urandom_range(7))
				0, 1: v = pool[$urandom_range(3)];   // repeats -> ties with the minimum
				2: v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				default: v = DATA_W'($urandom);
			endcase
			push_sample(v, i == len - 1);
		end
	endtask

	initial begin
		int unsigned ke;
		int unsigned len;
		int unsigned retune;
		int unsigned goal;
		logic [KEEP_W-1:0] k;

		arst_n              = 1'b0;
		keep_count_we       = 1'b0;
		keep_count_wdata    = '0;
		sample.valid        = 1'b0;
		sample.sample_value = '0;
		sample.last_in_run  = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: keep_count at reset value, single-sample runs at the extremes
		push_sample(16'sh7FFF, 1'b1);
		push_sample(16'sh8000, 1'b1);

		// keep_count of zero behaves as one
		settle();
		load_keep(KEEP_W'(0));
		push_sample(16'sd100, 1'b0);
		push_sample(-16'sd5, 1'b0);
		push_sample(16'sd7, 1'b1);

		// oversized keep_count clamps to the store size; run shorter than that
		settle();
		load_keep(KEEP_W'(127));
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sd300, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(16'sh7FFF, 1'b1);

		// ties with the smallest held value
		settle();
		load_keep(KEEP_W'(3));
		push_sample(16'sd5, 1'b0);
		push_sample(16'sd5, 1'b0);
		push_sample(16'sd9, 1'b0);
		push_sample(16'sd5, 1'b0);
		push_sample(16'sd5, 1'b1);

		// shrink keep_count mid-run with more values held than the new count
		settle();
		load_keep(KEEP_W'(4));
		push_sample(16'sd10, 1'b0);
		push_sample(16'sd20, 1'b0);
		push_sample(16'sd30, 1'b0);
		push_sample(16'sd40, 1'b0);
		push_sample(16'sd50, 1'b0);
		push_sample(16'sd60, 1'b0);
		settle();
		load_keep(KEEP_W'(2));
		push_sample(16'sd1, 1'b0);
		push_sample(16'sd70, 1'b1);

		// Random phases: idle modes rotate, keep_count covers both ends.
		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin src_idle_pct = 75; rx_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  rx_stall_pct = 75; end
				default: begin src_idle_pct = 12; rx_stall_pct = 12; end
			endcase
			settle();
			case (p)
				0: k = KEEP_W'(1);
				1: k = KEEP_W'(64);
				2: k = KEEP_W'(0);
				3: k = KEEP_W'(127);
				4: k = KEEP_W'($urandom_range(1, 8));
				default: k = $urandom_range(1) ? KEEP_W'($urandom_range(0, 127))
				                               : KEEP_W'($urandom_range(1, 16));
			endcase
			load_keep(k);
			// pressure: long receiver hold-off while short runs pile up
			if (p == 4)
				rx_hold_req = 1'b1;
			goal = sent_count + PHASE_ITEMS;
			while (sent_count < goal) begin
				ke = (sb.keep_reg == 0) ? 1 : int'(sb.keep_reg);
				if (ke > MAX_KEEP_DEF)
					ke = MAX_KEEP_DEF;
				if (p == 4)
					len = $urandom_range(1, 3);
				else begin
					case ($urandom_range(3))
						0: len = $urandom_range(1, ke);
						1: len = $urandom_range(ke, 2 * ke + 4);
						2: len = $urandom_range(1, 6);
						default: len = $urandom_range(1, 90);
					endcase
				end
				retune = ($urandom_range(9) == 0 && len > 2) ? $urandom_range(1, len - 1) : 0;
				send_run(len, retune);
			end
		end

		// drain, then give the block time to show any stray transfer
		settle();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// hang guard, well above the slowest legal run
	initial begin
		#1000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
